### hdl/ffuc_pkg.sv
// Package for the flag-framed unescape checker.
// Holds the beat payload types, byte codes and frame status codes.
// Has no dependencies.
package ffuc_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h01;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
  localparam int unsigned SUM_START   = 3;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_SUM_OK   = 2'd1,
    ST_SUM_BAD  = 2'd2,
    ST_ABORT    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_overflow;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] content_index;
    logic       frame_end;
    logic [1:0] frame_status;
  } res_beat_t;

  // Results produced by one input byte, in order; only the first cnt are used.
  typedef struct packed {
    logic [1:0] cnt;
    res_beat_t  r0;
    res_beat_t  r1;
  } push_t;

endpackage

### hdl/ffuc_if.sv
// Valid/ready channel interfaces for the flag-framed unescape checker.
// Does not depend on ffuc_pkg; its field widths mirror the package types.
interface ffuc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_overflow;

  modport source (output valid, output rx_byte, output rx_overflow, input ready);
  modport sink (input valid, input rx_byte, input rx_overflow, output ready);
endinterface

interface ffuc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [7:0] content_index;
  logic       frame_end;
  logic [1:0] frame_status;

  modport source (output valid, output out_byte, output content_index,
                  output frame_end, output frame_status, input ready);
  modport sink (input valid, input out_byte, input content_index,
                input frame_end, input frame_status, output ready);
endinterface

### hdl/ffuc_res_fifo.sv
// Four-entry result queue that takes up to two results per cycle.
// Depends on ffuc_pkg for the result and push types.
module ffuc_res_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_en,
  input  ffuc_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output ffuc_pkg::res_beat_t out_data
);

  ffuc_pkg::res_beat_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;
  logic [1:0] n_push;

  assign pop       = out_valid && out_ready;
  assign n_push    = push_en ? push.cnt : 2'd0;
  assign out_valid = (count != 3'd0);
  assign out_data  = slots[rd_ptr];
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (n_push == 2'd2) begin
      slots[wr_ptr + 2'd1] <= push.r1;
    end
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, n_push} - {2'b00, pop};
    end
  end

endmodule

### hdl/ffuc_core.sv
// Input register, frame state and per-byte unescape and checksum logic.
// Depends on ffuc_pkg for byte codes, status codes and beat types.
module ffuc_core #(
  parameter int MAX_CONTENT = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_ovf,
  input  logic            room,
  output logic            push_en,
  output ffuc_pkg::push_t push
);

  localparam int CW = $clog2(MAX_CONTENT + 1);
  localparam int XW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CONTENT);
  localparam logic [CW-1:0] CNT_SUM = CW'(ffuc_pkg::SUM_START);

  typedef struct packed {
    logic          in_frame;
    logic          esc;
    logic [CW-1:0] cnt;
    logic [7:0]    sum;
    logic [7:0]    chk;
    logic          too_long;
  } st_t;

  typedef struct packed {
    st_t                 st;
    logic                ok;
    ffuc_pkg::res_beat_t r;
  } emit_t;

  st_t        state;
  st_t        state_next;
  logic       v_q;
  logic [7:0] b_q;
  logic       ovf_q;
  logic       fire;

  function automatic logic [7:0] idx8(input logic [CW-1:0] c);
    logic [XW-1:0] wide;
    wide = XW'(c);
    return wide[7:0];
  endfunction

  function automatic st_t cleared(input logic in_frame);
    st_t s;
    s          = '0;
    s.in_frame = in_frame;
    return s;
  endfunction

  function automatic emit_t emit(input st_t s, input logic [7:0] v);
    emit_t e;
    e    = '0;
    e.st = s;
    if (s.cnt >= CNT_MAX) begin
      e.st.too_long = 1'b1;
    end else begin
      e.ok              = 1'b1;
      e.r.out_byte      = v;
      e.r.content_index = idx8(s.cnt);
      e.r.frame_end     = 1'b0;
      e.r.frame_status  = ffuc_pkg::ST_DATA;
      if (s.cnt == '0) begin
        e.st.chk = v;
      end
      if (s.cnt >= CNT_SUM) begin
        e.st.sum = s.sum + v;
      end
      e.st.cnt = s.cnt + 1'b1;
    end
    return e;
  endfunction

  function automatic ffuc_pkg::res_beat_t end_beat(input st_t s, input logic [1:0] status);
    ffuc_pkg::res_beat_t r;
    r.out_byte      = 8'd0;
    r.content_index = idx8(s.cnt);
    r.frame_end     = 1'b1;
    r.frame_status  = status;
    return r;
  endfunction

  assign fire     = v_q && room;
  assign in_ready = !v_q || room;
  assign push_en  = fire;

  always_comb begin
    emit_t               e1;
    emit_t               e2;
    st_t                 s;
    logic                v1;
    logic                v2;
    logic                used;
    ffuc_pkg::res_beat_t r1;
    ffuc_pkg::res_beat_t r2;
    logic [1:0]          status;

    e1         = '0;
    e2         = '0;
    s          = state;
    v1         = 1'b0;
    v2         = 1'b0;
    used       = 1'b0;
    r1         = '0;
    r2         = '0;
    status     = ffuc_pkg::ST_DATA;
    state_next = state;

    if (ovf_q) begin
      if (state.in_frame) begin
        v1         = 1'b1;
        r1         = end_beat(state, ffuc_pkg::ST_ABORT);
        state_next = cleared(1'b0);
      end
    end else if (!state.in_frame) begin
      if (b_q == ffuc_pkg::FLAG_BYTE) begin
        state_next = cleared(1'b1);
      end
    end else begin
      if (state.esc) begin
        s.esc = 1'b0;
        if (b_q == ffuc_pkg::ESC_FOR_FLAG) begin
          e1   = emit(s, ffuc_pkg::FLAG_BYTE);
          used = 1'b1;
        end else begin
          e1   = emit(s, ffuc_pkg::ESC_BYTE);
          used = (b_q == ffuc_pkg::ESC_FOR_ESC);
        end
        s  = e1.st;
        v1 = e1.ok;
        r1 = e1.r;
      end
      state_next = s;
      if (!used) begin
        if (b_q == ffuc_pkg::FLAG_BYTE) begin
          if (s.too_long) begin
            status = ffuc_pkg::ST_ABORT;
          end else if (s.cnt == '0) begin
            status = ffuc_pkg::ST_SUM_BAD;
          end else if (s.sum == s.chk) begin
            status = ffuc_pkg::ST_SUM_OK;
          end else begin
            status = ffuc_pkg::ST_SUM_BAD;
          end
          v2         = 1'b1;
          r2         = end_beat(s, status);
          state_next = cleared(1'b0);
        end else if (b_q == ffuc_pkg::ESC_BYTE) begin
          state_next.esc = 1'b1;
        end else begin
          e2         = emit(s, b_q);
          v2         = e2.ok;
          r2         = e2.r;
          state_next = e2.st;
        end
      end
    end

    push.cnt = {1'b0, v1} + {1'b0, v2};
    push.r0  = v1 ? r1 : r2;
    push.r1  = r2;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b_q   <= in_byte;
      ovf_q <= in_ovf;
    end
    if (rst) begin
      v_q   <= 1'b0;
      state <= cleared(1'b0);
    end else begin
      if (in_ready) begin
        v_q <= in_valid;
      end
      if (fire) begin
        state <= state_next;
      end
    end
  end

endmodule

### hdl/flag_framed_unescape_checker.sv
// The checker takes one received serial byte per beat and returns unescaped
// frame content bytes and an end-of-frame beat with the checksum status. It
// accepts one byte every cycle while the result queue has room; a byte that
// yields two results (a dangling escape before a closing flag or a plain
// byte) pushes both into the four-entry result queue, which absorbs them.
// A byte passes the input register and then the queue to the result port.
// Top level; depends on ffuc_pkg, ffuc_if, ffuc_core and ffuc_res_fifo.
module flag_framed_unescape_checker #(
  parameter int MAX_CONTENT = 256
) (
  input logic              clk,
  input logic              rst,
  ffuc_rx_if.sink          rx,
  ffuc_res_if.source       res
);

  logic                room;
  logic                push_en;
  ffuc_pkg::push_t     push;
  ffuc_pkg::res_beat_t head;

  ffuc_core #(
    .MAX_CONTENT(MAX_CONTENT)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .in_byte  (rx.rx_byte),
    .in_ovf   (rx.rx_overflow),
    .room     (room),
    .push_en  (push_en),
    .push     (push)
  );

  ffuc_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_en   (push_en),
    .push      (push),
    .room      (room),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (head)
  );

  assign res.out_byte      = head.out_byte;
  assign res.content_index = head.content_index;
  assign res.frame_end     = head.frame_end;
  assign res.frame_status  = head.frame_status;

endmodule
